// ===== sv/gbts_pkg.sv =====
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types, codes and helpers for the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

	localparam int CAPACITY_DEF  = 4096;
	localparam int MAX_LINES_DEF = 1024;

	localparam int IN_DATA_W  = 56;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 2;

	localparam logic [7:0] NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_READ   = 3'd2,
		CMD_LOCATE = 3'd3,
		CMD_SEEK   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_STORE_FULL = 2'd1,
		ST_LINES_FULL = 2'd2,
		ST_RANGE      = 2'd3
	} status_t;

	// character length from the UTF-8 lead byte
	function automatic logic [2:0] utf8_len(input logic [7:0] b);
		logic [2:0] n;
		if (b < 8'hC0)      n = 3'd1;
		else if (b < 8'hE0) n = 3'd2;
		else if (b < 8'hF0) n = 3'd3;
		else if (b < 8'hF8) n = 3'd4;
		else if (b < 8'hFC) n = 3'd5;
		else if (b < 8'hFE) n = 3'd6;
		else                n = 3'd1;
		return n;
	endfunction

endpackage

// ===== sv/gbts_ram.sv =====
// ----------------------------------------------------------------------------
// gbts_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module gbts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/gap_buffer_text_store.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Gap buffer of text bytes with a line length table, run by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  Commands enter on the s_ group: s_tuser carries the command code, s_tdata
//  the operands. One result item per command leaves on the m_ group, with the
//  status in m_tuser. s_tready is high only while the sequencer is idle; a
//  command is taken while the previous result still waits in the output
//  register, and its own result waits there until m_tready.
//  The run time depends on the command. Both stores have one write port and
//  one read port, and every step is a read state plus a check or write state:
//    read byte             : DECODE, RB_RD, RB_WT, then DONE
//    insert / delete       : grows with gap move distance, lines walked,
//                            table entries shifted and bytes deleted
//    position to line/col  : grows with lines walked and characters walked
//    line/col to position  : grows with target line and characters walked
//  A delete that merges many lines shifts the table once per merged newline.
//  Reset leaves one newline and a single empty line; no clearing pass is
//  needed, the untouched tail byte and line zero read as their reset values.
//  A stalled receiver holds only the output register; the sequencer finishes
//  the next command and then waits.
// ----------------------------------------------------------------------------
module gap_buffer_text_store #(
	parameter int CAPACITY  = gbts_pkg::CAPACITY_DEF,
	parameter int MAX_LINES = gbts_pkg::MAX_LINES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// position[11:0], data_byte[19:12], delete_count[32:20],
	// target_line[42:33], target_column[54:43], zero[55]
	input  logic [gbts_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd[2:0]
	input  logic [gbts_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_byte[7:0], line_index[17:8], column_index[29:18],
	// result_position[41:30], text_size[54:42], line_count[65:55], zero[71:66]
	output logic [gbts_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [gbts_pkg::OUT_USER_W-1:0] m_tuser
);

	import gbts_pkg::*;

	localparam int AW  = $clog2(CAPACITY);
	localparam int PW  = AW + 1;
	localparam int LW  = $clog2(MAX_LINES);
	localparam int LUW = LW + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_MV_RD, S_MV_WR, S_LOC_RD, S_LOC_CHK, S_INS_WR,
		S_SH_RD, S_SH_WR, S_SPL0, S_SPL1, S_DEL_RD, S_DEL_CHK, S_MRG_RD,
		S_MRG_WR, S_DSH_RD, S_DSH_WR, S_RB_RD, S_RB_WT, S_COL_RD, S_COL_CHK,
		S_SUM_RD, S_SUM_CHK, S_OFF_RD, S_OFF_CHK, S_DONE
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [11:0]     pos_q;
	logic [7:0]      byte_q;
	logic [12:0]     cnt_q;
	logic [9:0]      tline_q;
	logic [11:0]     tcol_q;
	logic [PW-1:0]   gs_q, ge_q;
	logic [LUW-1:0]  lu_q;
	logic            tail_wr_q, l0_wr_q, tovr_q, lovr_q;
	logic [LUW-1:0]  idx_q;
	logic [PW-1:0]   off_q, start_q, len_q, ptr_q, col_q, end_q;
	logic [LW-1:0]   line_q;
	logic [12:0]     rem_q;
	logic [7:0]      rb_q;
	status_t         st_q;
	logic            m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;

	logic            t_we, l_we;
	logic [AW-1:0]   t_waddr, t_raddr;
	logic [7:0]      t_wdata, t_rdata, tbyte;
	logic [LW-1:0]   l_waddr, l_raddr;
	logic [PW-1:0]   l_wdata, l_rdata, ldata;
	logic [PW-1:0]   size_w, pos_w, col_w, step_w, nxt_w;
	logic            move_left;

	function automatic logic [AW-1:0] phys(input logic [PW-1:0] p,
	                                        input logic [PW-1:0] gs,
	                                        input logic [PW-1:0] ge);
		logic [PW-1:0] a;
		a = (p < gs) ? p : PW'(p + (ge - gs));
		return a[AW-1:0];
	endfunction

	gbts_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_text (
		.clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	gbts_ram #(.WIDTH(PW), .DEPTH(MAX_LINES)) u_lines (
		.clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	assign tbyte     = tovr_q ? NEWLINE : t_rdata;
	assign ldata     = lovr_q ? '0 : l_rdata;
	assign size_w    = PW'(gs_q + (PW'(CAPACITY) - ge_q));
	assign pos_w     = PW'(pos_q);
	assign col_w     = PW'(pos_w - start_q);
	assign step_w    = PW'(utf8_len(tbyte));
	assign nxt_w     = PW'(off_q + step_w);
	assign move_left = gs_q > pos_w;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	always_comb begin
		t_we    = 1'b0;
		t_waddr = '0;
		t_wdata = '0;
		t_raddr = '0;
		l_we    = 1'b0;
		l_waddr = '0;
		l_wdata = '0;
		l_raddr = '0;
		unique case (state_q)
			S_MV_RD: begin
				t_raddr = move_left ? AW'(gs_q - 1'b1) : ge_q[AW-1:0];
			end
			S_MV_WR: begin
				t_we    = 1'b1;
				t_wdata = tbyte;
				t_waddr = move_left ? AW'(ge_q - 1'b1) : gs_q[AW-1:0];
			end
			S_LOC_RD, S_SUM_RD: begin
				l_raddr = idx_q[LW-1:0];
			end
			S_INS_WR: begin
				t_we    = 1'b1;
				t_waddr = gs_q[AW-1:0];
				t_wdata = byte_q;
				if (byte_q != NEWLINE) begin
					l_we    = 1'b1;
					l_waddr = line_q;
					l_wdata = PW'(len_q + 1'b1);
				end
			end
			S_SH_RD: begin
				l_raddr = LW'(idx_q - 1'b1);
			end
			S_SH_WR: begin
				l_we    = 1'b1;
				l_waddr = idx_q[LW-1:0];
				l_wdata = ldata;
			end
			S_SPL0: begin
				l_we    = 1'b1;
				l_waddr = line_q;
				l_wdata = col_w;
			end
			S_SPL1: begin
				l_we    = 1'b1;
				l_waddr = LW'(line_q + 1'b1);
				l_wdata = PW'(len_q - col_w);
			end
			S_DEL_RD: begin
				t_raddr = ptr_q[AW-1:0];
			end
			S_DEL_CHK: begin
				if (!(tbyte == NEWLINE && line_q != '0) && len_q != '0) begin
					l_we    = 1'b1;
					l_waddr = line_q;
					l_wdata = PW'(len_q - 1'b1);
				end
			end
			S_MRG_RD: begin
				l_raddr = LW'(line_q - 1'b1);
			end
			S_MRG_WR: begin
				l_we    = 1'b1;
				l_waddr = LW'(line_q - 1'b1);
				l_wdata = PW'(ldata + len_q);
			end
			S_DSH_RD: begin
				l_raddr = LW'(idx_q + 1'b1);
			end
			S_DSH_WR: begin
				l_we    = 1'b1;
				l_waddr = idx_q[LW-1:0];
				l_wdata = ldata;
			end
			S_RB_RD: begin
				t_raddr = phys(pos_w, gs_q, ge_q);
			end
			S_COL_RD: begin
				t_raddr = phys(ptr_q, gs_q, ge_q);
			end
			S_OFF_RD: begin
				t_raddr = phys(off_q, gs_q, ge_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			gs_q      <= '0;
			ge_q      <= PW'(CAPACITY - 1);
			lu_q      <= LUW'(1);
			tail_wr_q <= 1'b0;
			l0_wr_q   <= 1'b0;
			tovr_q    <= 1'b0;
			lovr_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			tovr_q <= (t_raddr == AW'(CAPACITY - 1)) && !tail_wr_q;
			lovr_q <= (l_raddr == '0) && !l0_wr_q;
			if (t_we && t_waddr == AW'(CAPACITY - 1)) tail_wr_q <= 1'b1;
			if (l_we && l_waddr == '0) l0_wr_q <= 1'b1;
			if (state_q == S_DONE && (!m_valid_q || m_tready)) m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready) m_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= cmd_t'(s_tuser[2:0]);
						pos_q   <= s_tdata[11:0];
						byte_q  <= s_tdata[19:12];
						cnt_q   <= s_tdata[32:20];
						tline_q <= s_tdata[42:33];
						tcol_q  <= s_tdata[54:43];
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					rb_q    <= '0;
					st_q    <= ST_OK;
					state_q <= S_DONE;
					idx_q   <= '0;
					off_q   <= '0;
					col_q   <= '0;
					case (cmd_q)
						CMD_INSERT: begin
							if (32'(pos_q) >= 32'(size_w)) st_q <= ST_RANGE;
							else if (ge_q <= gs_q) st_q <= ST_STORE_FULL;
							else if (byte_q == NEWLINE && 32'(lu_q) >= MAX_LINES)
								st_q <= ST_LINES_FULL;
							else state_q <= S_MV_RD;
						end
						CMD_DELETE: begin
							if (cnt_q > 13'(pos_q) || 32'(pos_q) > 32'(size_w)) begin
								st_q <= ST_RANGE;
							end else if (32'(pos_q) == 32'(size_w)) begin
								if (32'(cnt_q) != 32'(size_w)) begin
									st_q <= ST_RANGE;
								end else begin
									gs_q      <= '0;
									ge_q      <= PW'(CAPACITY - 1);
									lu_q      <= LUW'(1);
									tail_wr_q <= 1'b0;
									l0_wr_q   <= 1'b0;
								end
							end else if (cnt_q != '0) begin
								state_q <= S_MV_RD;
							end
						end
						CMD_READ: begin
							if (32'(pos_q) < 32'(size_w)) state_q <= S_RB_RD;
							else st_q <= ST_RANGE;
						end
						CMD_LOCATE: begin
							if (32'(pos_q) < 32'(size_w)) state_q <= S_LOC_RD;
							else st_q <= ST_RANGE;
						end
						CMD_SEEK: begin
							if (32'(tline_q) < 32'(lu_q)) state_q <= S_SUM_RD;
							else st_q <= ST_RANGE;
						end
						default: begin
						end
					endcase
				end
				S_MV_RD: begin
					if (gs_q == pos_w) state_q <= S_LOC_RD;
					else state_q <= S_MV_WR;
				end
				S_MV_WR: begin
					if (move_left) begin
						gs_q <= gs_q - 1'b1;
						ge_q <= ge_q - 1'b1;
					end else begin
						gs_q <= gs_q + 1'b1;
						ge_q <= ge_q + 1'b1;
					end
					state_q <= S_MV_RD;
				end
				S_LOC_RD: begin
					state_q <= S_LOC_CHK;
				end
				S_LOC_CHK: begin
					if (pos_w <= PW'(off_q + ldata) || 32'(idx_q) + 1 == 32'(lu_q)) begin
						line_q  <= idx_q[LW-1:0];
						start_q <= off_q;
						len_q   <= ldata;
						case (cmd_q)
							CMD_INSERT: state_q <= S_INS_WR;
							CMD_DELETE: begin
								ptr_q   <= PW'(gs_q - 1'b1);
								rem_q   <= cnt_q;
								state_q <= S_DEL_RD;
							end
							default: begin
								ptr_q   <= off_q;
								col_q   <= '0;
								state_q <= S_COL_RD;
							end
						endcase
					end else begin
						off_q   <= PW'(off_q + ldata + 1'b1);
						idx_q   <= idx_q + 1'b1;
						state_q <= S_LOC_RD;
					end
				end
				S_INS_WR: begin
					gs_q <= gs_q + 1'b1;
					if (byte_q == NEWLINE) begin
						idx_q   <= lu_q;
						state_q <= S_SH_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SH_RD: begin
					if (32'(idx_q) > 32'(line_q) + 1) state_q <= S_SH_WR;
					else state_q <= S_SPL0;
				end
				S_SH_WR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= S_SH_RD;
				end
				S_SPL0: begin
					state_q <= S_SPL1;
				end
				S_SPL1: begin
					lu_q    <= lu_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DEL_RD: begin
					if (rem_q == '0) begin
						gs_q    <= PW'(gs_q - PW'(cnt_q));
						state_q <= S_DONE;
					end else begin
						state_q <= S_DEL_CHK;
					end
				end
				S_DEL_CHK: begin
					ptr_q <= ptr_q - 1'b1;
					rem_q <= rem_q - 1'b1;
					if (tbyte == NEWLINE && line_q != '0) begin
						state_q <= S_MRG_RD;
					end else begin
						if (len_q != '0) len_q <= len_q - 1'b1;
						state_q <= S_DEL_RD;
					end
				end
				S_MRG_RD: begin
					state_q <= S_MRG_WR;
				end
				S_MRG_WR: begin
					len_q   <= PW'(ldata + len_q);
					idx_q   <= LUW'(line_q);
					state_q <= S_DSH_RD;
				end
				S_DSH_RD: begin
					if (32'(idx_q) + 1 < 32'(lu_q)) begin
						state_q <= S_DSH_WR;
					end else begin
						lu_q    <= lu_q - 1'b1;
						line_q  <= line_q - 1'b1;
						state_q <= S_DEL_RD;
					end
				end
				S_DSH_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_DSH_RD;
				end
				S_RB_RD: begin
					state_q <= S_RB_WT;
				end
				S_RB_WT: begin
					rb_q    <= tbyte;
					state_q <= S_DONE;
				end
				S_COL_RD: begin
					if (ptr_q < pos_w) state_q <= S_COL_CHK;
					else state_q <= S_DONE;
				end
				S_COL_CHK: begin
					ptr_q   <= PW'(ptr_q + step_w);
					col_q   <= col_q + 1'b1;
					state_q <= S_COL_RD;
				end
				S_SUM_RD: begin
					state_q <= S_SUM_CHK;
				end
				S_SUM_CHK: begin
					if (32'(idx_q) == 32'(tline_q)) begin
						end_q   <= PW'(off_q + ldata);
						col_q   <= '0;
						state_q <= S_OFF_RD;
					end else begin
						off_q   <= PW'(off_q + ldata + 1'b1);
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SUM_RD;
					end
				end
				S_OFF_RD: begin
					if (32'(col_q) < 32'(tcol_q) && off_q < end_q) state_q <= S_OFF_CHK;
					else state_q <= S_DONE;
				end
				S_OFF_CHK: begin
					off_q   <= (nxt_w > end_q) ? end_q : nxt_w;
					col_q   <= col_q + 1'b1;
					state_q <= S_OFF_RD;
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_user_q  <= st_q;
						m_data_q  <= {
							6'd0,
							11'(lu_q),
							13'(size_w),
							(cmd_q == CMD_SEEK && st_q == ST_OK) ? 12'(off_q) : 12'd0,
							(cmd_q == CMD_LOCATE && st_q == ST_OK) ? 12'(col_q) : 12'd0,
							(cmd_q == CMD_LOCATE && st_q == ST_OK) ? 10'(line_q) : 10'd0,
							rb_q
						};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gs_q <= ge_q)
		else $error("gap start passed gap end");

	a_gap_end: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ge_q) <= CAPACITY)
		else $error("gap end beyond store");

	a_lines_range: assert property (@(posedge clk) disable iff (!arst_n)
		lu_q != '0 && 32'(lu_q) <= MAX_LINES)
		else $error("line count out of range");

	a_newlines_fit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_w) >= 32'(lu_q))
		else $error("more lines than text bytes");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gap buffer text store. A directed table walks
// reset contents, range errors and UTF-8 corner cases, then random edit
// sequences run against a behavioral text store under several idle and
// stall phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gbts_pkg::*;

	localparam int CAP  = 4096;
	localparam int MAXL = 1024;
	localparam int WATCHDOG = 40000;

	typedef struct packed {
		logic [7:0]  rbyte;
		logic [9:0]  line;
		logic [11:0] col;
		logic [11:0] rpos;
		logic [12:0] size;
		logic [10:0] lines;
		logic [1:0]  status;
	} text_result_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [11:0] pos;
		logic [7:0]  data;
		logic [12:0] count;
		logic [9:0]  tline;
		logic [11:0] tcol;
		bit          known;
		text_result_t res;
	} edit_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	gap_buffer_text_store i_dut (.*);

	always #10 clk = ~clk;

	// behavioral text store
	logic [7:0]  store [CAP];
	int unsigned gstart, gend, nlines;
	int unsigned llen [MAXL];

	text_result_t pending_q [$];
	int errors = 0;
	int idle_pct = 0, stall_pct = 0;
	int quiet = 0;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic int unsigned char_len(logic [7:0] b);
		if (b < 8'hC0) return 1;
		if (b < 8'hE0) return 2;
		if (b < 8'hF0) return 3;
		if (b < 8'hF8) return 4;
		if (b < 8'hFC) return 5;
		if (b < 8'hFE) return 6;
		return 1;
	endfunction

	function automatic int unsigned text_len();
		return gstart + CAP - gend;
	endfunction

	function automatic logic [7:0] byte_at(int unsigned p);
		return store[(p < gstart ? p : p + gend - gstart) % CAP];
	endfunction

	function automatic void clear_text();
		foreach (store[i]) store[i] = 8'h00;
		foreach (llen[i]) llen[i] = 0;
		store[CAP-1] = NEWLINE;
		gstart = 0;
		gend = CAP - 1;
		nlines = 1;
	endfunction

	function automatic void shift_gap(int unsigned p);
		while (gstart > p && gstart > 0) begin
			gstart--;
			gend--;
			store[gend % CAP] = store[gstart % CAP];
		end
		while (gstart < p && gend < CAP) begin
			store[gstart % CAP] = store[gend % CAP];
			gstart++;
			gend++;
		end
	endfunction

	function automatic void find_line(int unsigned p, output int unsigned ln,
			output int unsigned st);
		int unsigned off;
		off = 0;
		for (int unsigned i = 0; i < nlines; i++) begin
			if (p <= off + llen[i]) begin
				ln = i;
				st = off;
				return;
			end
			if (i + 1 < nlines) off += llen[i] + 1;
		end
		ln = nlines - 1;
		st = off;
	endfunction

	function automatic logic [1:0] apply_insert(int unsigned p, logic [7:0] b);
		int unsigned ln, st, c, old;
		if (p >= text_len()) return ST_RANGE;
		if (gend <= gstart) return ST_STORE_FULL;
		if (b == NEWLINE && nlines >= MAXL) return ST_LINES_FULL;
		shift_gap(p);
		find_line(p, ln, st);
		store[gstart % CAP] = b;
		gstart++;
		if (b == NEWLINE) begin
			c = p - st;
			old = llen[ln];
			for (int unsigned i = nlines; i > ln + 1; i--)
				llen[i % MAXL] = llen[(i - 1) % MAXL];
			llen[ln] = c;
			llen[(ln + 1) % MAXL] = old - c;
			nlines++;
		end else begin
			llen[ln]++;
		end
		return ST_OK;
	endfunction

	function automatic logic [1:0] apply_delete(int unsigned p, int unsigned n);
		int unsigned sz, ln, st;
		logic [7:0] c;
		sz = text_len();
		if (n > p || p > sz) return ST_RANGE;
		if (p == sz) begin
			if (n != sz) return ST_RANGE;
			clear_text();
			return ST_OK;
		end
		if (n == 0) return ST_OK;
		shift_gap(p);
		find_line(p, ln, st);
		for (int unsigned k = 0; k < n; k++) begin
			c = store[(gstart - 1 - k) % CAP];
			if (c == NEWLINE && ln > 0) begin
				llen[ln-1] += llen[ln];
				for (int unsigned i = ln; i + 1 < nlines; i++) llen[i] = llen[i+1];
				nlines--;
				ln--;
			end else if (llen[ln] > 0) begin
				llen[ln]--;
			end
		end
		gstart -= n;
		return ST_OK;
	endfunction

	function automatic text_result_t predict_edit(edit_row_t r);
		text_result_t o;
		int unsigned ln, st, off, e, i;
		o = '0;
		case (r.cmd)
			CMD_INSERT: o.status = apply_insert(r.pos, r.data);
			CMD_DELETE: o.status = apply_delete(r.pos, r.count);
			CMD_READ:
				if (r.pos < text_len()) o.rbyte = byte_at(r.pos);
				else o.status = ST_RANGE;
			CMD_LOCATE:
				if (r.pos < text_len()) begin
					find_line(r.pos, ln, st);
					o.line = 10'(ln);
					for (i = st; i < r.pos; i += char_len(byte_at(i))) o.col++;
				end else begin
					o.status = ST_RANGE;
				end
			CMD_SEEK:
				if (r.tline < nlines) begin
					off = 0;
					for (i = 0; i < r.tline; i++) off += llen[i] + 1;
					e = off + llen[r.tline];
					for (i = 0; i < r.tcol && off < e; i++) begin
						off += char_len(byte_at(off));
						if (off > e) off = e;
					end
					o.rpos = 12'(off);
				end else begin
					o.status = ST_RANGE;
				end
			default: ;
		endcase
		o.size = 13'(text_len());
		o.lines = 11'(nlines);
		return o;
	endfunction

	function automatic edit_row_t mk(logic [2:0] c, int p, int d = 0, int n = 0,
			int tl = 0, int tc = 0);
		edit_row_t r;
		r.cmd = c; r.pos = 12'(p); r.data = 8'(d); r.count = 13'(n);
		r.tline = 10'(tl); r.tcol = 12'(tc);
		r.known = 1'b0;
		r.res = '0;
		return r;
	endfunction

	function automatic edit_row_t mk_known(edit_row_t r, int sz, int nl, int st,
			int rb = 0);
		r.known = 1'b1;
		r.res = '0;
		r.res.size = 13'(sz);
		r.res.lines = 11'(nl);
		r.res.status = 2'(st);
		r.res.rbyte = 8'(rb);
		return r;
	endfunction

	task automatic send_edit(edit_row_t r);
		text_result_t p;
		@(negedge clk);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
		s_tdata <= {1'b0, r.tcol, r.tline, r.count, r.data, r.pos};
		s_tuser <= r.cmd;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		p = predict_edit(r);
		if (r.known && p != r.res) report("table row", p[31:0], r.res[31:0]);
		pending_q.push_back(p);
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// random edit: mostly valid positions in the current text
	function automatic edit_row_t rand_edit();
		edit_row_t r;
		int unsigned sz, k;
		sz = text_len();
		k = $urandom_range(99);
		r = mk(CMD_READ, 0);
		r.pos = (k < 90) ? 12'($urandom_range(sz - 1)) : 12'($urandom);
		r.data = 8'($urandom);
		r.count = 13'($urandom);
		r.tline = 10'($urandom);
		r.tcol = 12'($urandom);
		if (k < 40) begin
			r.cmd = CMD_INSERT;
			if ($urandom_range(3) == 0) r.data = NEWLINE;
			else if ($urandom_range(2) == 0) r.data = 8'(8'hC0 + $urandom_range(63));
		end else if (k < 55) begin
			r.cmd = CMD_DELETE;
			r.count = 13'($urandom_range(3));
			if (r.pos < r.count) r.pos = 12'(r.count);
			if (k == 54) begin r.pos = 12'(sz); r.count = 13'(sz); end
		end else if (k < 68) begin
			r.cmd = CMD_READ;
		end else if (k < 80) begin
			r.cmd = CMD_LOCATE;
		end else if (k < 95) begin
			r.cmd = CMD_SEEK;
			r.tline = 10'($urandom_range(nlines));
			r.tcol = 12'($urandom_range(6));
		end else begin
			r.cmd = 3'($urandom_range(7, 5));
		end
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		text_result_t got, want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (m_tvalid && m_tready) begin
				got = {m_tdata[7:0], m_tdata[17:8], m_tdata[29:18], m_tdata[41:30],
				       m_tdata[54:42], m_tdata[65:55], m_tuser};
				if (pending_q.size() == 0) begin
					report("unexpected item", 32'(got.status), 0);
				end else begin
					want = pending_q.pop_front();
					if (got.rbyte != want.rbyte)
						report("read_byte", 32'(got.rbyte), 32'(want.rbyte));
					if (got.line != want.line)
						report("line_index", 32'(got.line), 32'(want.line));
					if (got.col != want.col)
						report("column_index", 32'(got.col), 32'(want.col));
					if (got.rpos != want.rpos)
						report("result_position", 32'(got.rpos), 32'(want.rpos));
					if (got.size != want.size)
						report("text_size", 32'(got.size), 32'(want.size));
					if (got.lines != want.lines)
						report("line_count", 32'(got.lines), 32'(want.lines));
					if (got.status != want.status)
						report("status", 32'(got.status), 32'(want.status));
				end
			end
			if (quiet >= WATCHDOG) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk)
		m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

	edit_row_t table_rows [$];

	initial begin
		clear_text();
		table_rows = '{
			mk_known(mk(CMD_READ, 0), 1, 1, ST_OK, NEWLINE),
			mk_known(mk(CMD_READ, 1), 1, 1, ST_RANGE),
			mk_known(mk(CMD_INSERT, 1, 8'h41), 1, 1, ST_RANGE),
			mk_known(mk(CMD_INSERT, 0, 8'hFF), 2, 1, ST_OK),
			mk_known(mk(CMD_INSERT, 0, 8'h00), 3, 1, ST_OK),
			mk(CMD_INSERT, 1, NEWLINE),
			mk(CMD_INSERT, 0, 8'hE2),
			mk(CMD_INSERT, 1, 8'h82),
			mk(CMD_INSERT, 2, 8'hFC),
			mk(CMD_LOCATE, 1),
			mk(CMD_LOCATE, 3),
			mk(CMD_LOCATE, 4095),
			mk(CMD_SEEK, 0, 0, 0, 0, 4095),
			mk(CMD_SEEK, 0, 0, 0, 1, 1),
			mk(CMD_SEEK, 0, 0, 0, 1023, 0),
			mk(CMD_DELETE, 3, 0, 4),
			mk(CMD_DELETE, 3, 0, 0),
			mk(CMD_DELETE, 4095, 0, 8191),
			mk(CMD_DELETE, 3, 0, 2),
			mk(CMD_DELETE, 5, 0, 3),
			mk(3'd5, 4095, 255, 8191, 1023, 4095),
			mk(3'd7, 0)
		};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (table_rows[i]) send_edit(table_rows[i]);
		// wipe via deleting the whole text including the final newline
		send_edit(mk(CMD_DELETE, int'(text_len()), 0, int'(text_len())));
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 47 : (ph == 3) ? 24 : 0;
			stall_pct = (ph == 2) ? 47 : (ph == 3) ? 24 : 0;
			for (int i = 0; i < 29; i++) send_edit(rand_edit());
			if (ph == 1) drain();
		end
		idle_pct = 0;
		drain();
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
